FILE: rtl/box_point_signed_distance_top_macros.svh
// assertion macros for the box point signed distance block
`ifndef BOX_POINT_SIGNED_DISTANCE_TOP_MACROS_SVH
`define BOX_POINT_SIGNED_DISTANCE_TOP_MACROS_SVH

// same-cycle implication, disabled while dis is high
`define BPSD_ASSERT_IMP(lbl, clk, dis, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("box distance check failed");

// next-cycle implication, disabled while dis is high
`define BPSD_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("box distance check failed");

`endif

FILE: rtl/bpsd_pkg.sv
// shared types, constants and register codes of the box point signed distance block
package bpsd_pkg;

   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int DIMENSIONS_DEFAULT  = 3;
   localparam int DIST_WIDTH          = 26;
   localparam int RSP_DATA_WIDTH      = ((DIST_WIDTH + 7) / 8) * 8;
   localparam int CSR_INDEX_WIDTH     = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LOW_X  = 3'd0,
      CSR_LOW_Y  = 3'd1,
      CSR_LOW_Z  = 3'd2,
      CSR_HIGH_X = 3'd3,
      CSR_HIGH_Y = 3'd4,
      CSR_HIGH_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic in_box;
   } cell_ctl_type;

   function automatic csr_index_type csr_low_code(input int axis);
      csr_index_type code;
      unique case (axis)
         0:       code = CSR_LOW_X;
         1:       code = CSR_LOW_Y;
         default: code = CSR_LOW_Z;
      endcase
      return code;
   endfunction

   function automatic csr_index_type csr_high_code(input int axis);
      csr_index_type code;
      unique case (axis)
         0:       code = CSR_HIGH_X;
         1:       code = CSR_HIGH_Y;
         default: code = CSR_HIGH_Z;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/bpsd_axis.sv
// one axis of the front end: face tests, overshoot square and smallest face gap
module bpsd_axis #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] point,
   input  logic signed [COORD_WIDTH-1:0] low,
   input  logic signed [COORD_WIDTH-1:0] high,
   output logic                          in_box,
   output logic [2*COORD_WIDTH-1:0]      square,
   output logic [COORD_WIDTH-1:0]        gap_min
);

   localparam int EXT_W = COORD_WIDTH + 1;

   logic signed [EXT_W-1:0] pe, le, he;
   logic signed [EXT_W-1:0] d_above, d_below;
   logic                    above, below;

   logic [COORD_WIDTH-1:0]  over_ff, over_in;
   logic [COORD_WIDTH-1:0]  gap_hi_ff, gap_hi_in;
   logic [COORD_WIDTH-1:0]  gap_lo_ff, gap_lo_in;
   logic                    in_a_ff, in_a_in;

   logic [2*COORD_WIDTH-1:0] sq_ff, sq_in;
   logic [COORD_WIDTH-1:0]   gmin_ff, gmin_in;
   logic                     in_b_ff;

   // first stage: differences against both faces
   always_comb begin
      pe      = EXT_W'(point);
      le      = EXT_W'(low);
      he      = EXT_W'(high);
      above   = pe > he;
      below   = pe < le;
      d_above = pe - he;
      d_below = le - pe;
      if (above) begin
         over_in = d_above[COORD_WIDTH-1:0];
      end else if (below) begin
         over_in = d_below[COORD_WIDTH-1:0];
      end else begin
         over_in = '0;
      end
      in_a_in   = !above && !below;
      gap_hi_in = (~d_above[COORD_WIDTH-1:0]) + COORD_WIDTH'(1);
      gap_lo_in = (~d_below[COORD_WIDTH-1:0]) + COORD_WIDTH'(1);
   end

   // second stage: square of the overshoot and nearer face
   always_comb begin
      sq_in   = (2*COORD_WIDTH)'(over_ff) * (2*COORD_WIDTH)'(over_ff);
      gmin_in = (gap_hi_ff < gap_lo_ff) ? gap_hi_ff : gap_lo_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         over_ff   <= over_in;
         gap_hi_ff <= gap_hi_in;
         gap_lo_ff <= gap_lo_in;
         in_a_ff   <= in_a_in;
         sq_ff     <= sq_in;
         gmin_ff   <= gmin_in;
         in_b_ff   <= in_a_ff;
      end
   end

   assign in_box  = in_b_ff;
   assign square  = sq_ff;
   assign gap_min = gmin_ff;

endmodule

FILE: rtl/bpsd_root_cell.sv
// one square root cell: settles one root bit and passes the item to the next cell
module bpsd_root_cell #(
   parameter int COORD_WIDTH = 24,
   parameter int BIT         = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  bpsd_pkg::cell_ctl_type            up_ctl,
   input  logic [COORD_WIDTH-1:0]            up_gap,
   input  logic [2*COORD_WIDTH+1:0]          up_rem,
   input  logic [COORD_WIDTH:0]              up_root,
   output bpsd_pkg::cell_ctl_type            down_ctl,
   output logic [COORD_WIDTH-1:0]            down_gap,
   output logic [2*COORD_WIDTH+1:0]          down_rem,
   output logic [COORD_WIDTH:0]              down_root
);
   import bpsd_pkg::*;

   localparam int SUM_W  = 2 * COORD_WIDTH + 2;
   localparam int ROOT_W = COORD_WIDTH + 1;

   cell_ctl_type        ctl_ff, ctl_in;
   logic [COORD_WIDTH-1:0] gap_ff, gap_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SUM_W-1:0]    trial;
   logic                fits;

   // trial = 2 * root * 2^bit + 4^bit, remainder holds n - root^2
   always_comb begin
      trial  = (SUM_W'(up_root) << (BIT + 1)) | (SUM_W'(1) << (2 * BIT));
      fits   = up_rem >= trial;
      ctl_in = up_ctl;
      gap_in = up_gap;
      if (fits) begin
         rem_in  = up_rem - trial;
         root_in = up_root | (ROOT_W'(1) << BIT);
      end else begin
         rem_in  = up_rem;
         root_in = up_root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gap_ff  <= gap_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign down_ctl  = ctl_ff;
   assign down_gap  = gap_ff;
   assign down_rem  = rem_ff;
   assign down_root = root_ff;

endmodule

FILE: rtl/box_point_signed_distance_top.sv
// top level of the axis-aligned box point signed distance block
//
// usage
//   the box is loaded through the csr port: csr_we with csr_index 0..5 writes
//   low x, y, z and high x, y, z (signed Q8.16); other indexes are dropped.
//   load only while no item is in flight.
//   query points enter on req_* (x, y, z packed in req_tdata), one result
//   leaves on rsp_* per point: rsp_tuser is the inside flag, rsp_tdata holds
//   the signed Q.16 distance (minus the nearest face gap inside, truncated
//   euclidean distance outside).
// pipeline and throughput
//   an item passes two front stages per axis, one sum stage, one cell per root
//   bit and the output register, the first of them loaded at the accepting edge.
//   one item per cycle sustained while the pipe is not stalled; every cell of
//   the root row holds its own item.
// reset
//   synchronous reset empties the pipe and the output, box registers go to 0.
// stall
//   while rsp_tready is low the result holds; one more item lands in a skid
//   register, after which req_tready drops and the whole pipe freezes.
module box_point_signed_distance_top #(
   parameter  int COORD_WIDTH    = bpsd_pkg::COORD_WIDTH_DEFAULT,
   parameter  int DIMENSIONS     = bpsd_pkg::DIMENSIONS_DEFAULT,
   localparam int REQ_DATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write port
   input  logic                                  csr_we,
   input  logic [bpsd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COORD_WIDTH-1:0]                csr_wdata,
   // query points
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]             req_tdata,  // point_x, point_y, point_z
   // results
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bpsd_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,  // distance
   output logic                                  rsp_tuser   // inside_res
);
   import bpsd_pkg::*;

   localparam int SUM_W     = 2 * COORD_WIDTH + 2;
   localparam int ROOT_W    = COORD_WIDTH + 1;
   localparam int NEG_WIDTH = (COORD_WIDTH + 1 > DIST_WIDTH) ? COORD_WIDTH + 1 : DIST_WIDTH;

   // box registers, only the axes in use
   logic signed [COORD_WIDTH-1:0] low_ff  [DIMENSIONS];
   logic signed [COORD_WIDTH-1:0] high_ff [DIMENSIONS];

   // pipe control: all stages before the output register move together unless the skid is occupied
   logic en;
   logic accept;
   logic valid_a_ff, valid_b_ff, valid_c_ff;

   // per-axis front end outputs
   logic                     axis_in   [DIMENSIONS];
   logic [2*COORD_WIDTH-1:0] axis_sq   [DIMENSIONS];
   logic [COORD_WIDTH-1:0]   axis_gmin [DIMENSIONS];

   // sum stage
   logic [SUM_W-1:0]       sum_c_ff, sum_c_in;
   logic                   inside_c_ff, inside_c_in;
   logic [COORD_WIDTH-1:0] best_c_ff, best_c_in;

   // root cell chain
   cell_ctl_type           chain_ctl  [ROOT_W+1];
   logic [COORD_WIDTH-1:0] chain_gap  [ROOT_W+1];
   logic [SUM_W-1:0]       chain_rem  [ROOT_W+1];
   logic [ROOT_W-1:0]      chain_root [ROOT_W+1];

   // output register and skid
   logic                  out_valid_ff, out_valid_in;
   logic                  out_inside_ff, out_inside_in;
   logic [DIST_WIDTH-1:0] out_dist_ff, out_dist_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic                  skid_inside_ff, skid_inside_in;
   logic [DIST_WIDTH-1:0] skid_dist_ff, skid_dist_in;
   logic                  res_valid;
   logic                  res_inside;
   logic [DIST_WIDTH-1:0] res_dist;
   logic [NEG_WIDTH-1:0]  res_neg;
   logic [NEG_WIDTH-1:0]  res_root;
   logic                  take;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   // config decode and front end, one slice per axis in use
   for (genvar d = 0; d < DIMENSIONS; d++) begin : g_axis
      always_ff @(posedge clock) begin
         if (reset) begin
            low_ff[d]  <= '0;
            high_ff[d] <= '0;
         end else if (csr_we) begin
            if (csr_index == csr_low_code(d)) begin
               low_ff[d] <= csr_wdata;
            end
            if (csr_index == csr_high_code(d)) begin
               high_ff[d] <= csr_wdata;
            end
         end
      end

      bpsd_axis #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_axis (
         .clock   (clock),
         .en      (en),
         .point   (req_tdata[d*COORD_WIDTH +: COORD_WIDTH]),
         .low     (low_ff[d]),
         .high    (high_ff[d]),
         .in_box  (axis_in[d]),
         .square  (axis_sq[d]),
         .gap_min (axis_gmin[d])
      );
   end

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= accept;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   // sum of squared overshoots, inside test over all axes, nearest face
   always_comb begin
      sum_c_in    = SUM_W'(axis_sq[0]);
      inside_c_in = axis_in[0];
      best_c_in   = axis_gmin[0];
      for (int d = 1; d < DIMENSIONS; d++) begin
         sum_c_in    = sum_c_in + SUM_W'(axis_sq[d]);
         inside_c_in = inside_c_in && axis_in[d];
         if (axis_gmin[d] < best_c_in) begin
            best_c_in = axis_gmin[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_c_ff    <= sum_c_in;
         inside_c_ff <= inside_c_in;
         best_c_ff   <= best_c_in;
      end
   end

   // head of the root chain: full radicand, empty root
   assign chain_ctl[0]  = '{valid: valid_c_ff, in_box: inside_c_ff};
   assign chain_gap[0]  = best_c_ff;
   assign chain_rem[0]  = sum_c_ff;
   assign chain_root[0] = '0;

   // one cell per root bit, most significant first
   for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
      bpsd_root_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .BIT         (ROOT_W - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .up_ctl    (chain_ctl[k]),
         .up_gap    (chain_gap[k]),
         .up_rem    (chain_rem[k]),
         .up_root   (chain_root[k]),
         .down_ctl  (chain_ctl[k+1]),
         .down_gap  (chain_gap[k+1]),
         .down_rem  (chain_rem[k+1]),
         .down_root (chain_root[k+1])
      );
   end

   // final distance: negated gap inside, root outside
   always_comb begin
      res_valid  = en && chain_ctl[ROOT_W].valid;
      res_inside = chain_ctl[ROOT_W].in_box;
      res_neg    = NEG_WIDTH'(0) - NEG_WIDTH'(chain_gap[ROOT_W]);
      res_root   = NEG_WIDTH'(chain_root[ROOT_W]);
      res_dist   = res_inside ? res_neg[DIST_WIDTH-1:0] : res_root[DIST_WIDTH-1:0];
   end

   // output register with skid, skid drains first
   always_comb begin
      take           = out_valid_ff && rsp_tready;
      out_valid_in   = out_valid_ff;
      out_inside_in  = out_inside_ff;
      out_dist_in    = out_dist_ff;
      skid_valid_in  = skid_valid_ff;
      skid_inside_in = skid_inside_ff;
      skid_dist_in   = skid_dist_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_inside_in = skid_inside_ff;
            out_dist_in   = skid_dist_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = res_valid;
            out_inside_in = res_inside;
            out_dist_in   = res_dist;
         end
      end else if (res_valid) begin
         skid_valid_in  = 1'b1;
         skid_inside_in = res_inside;
         skid_dist_in   = res_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_inside_ff  <= out_inside_in;
      out_dist_ff    <= out_dist_in;
      skid_inside_ff <= skid_inside_in;
      skid_dist_ff   <= skid_dist_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_inside_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - DIST_WIDTH){1'b0}}, out_dist_ff};

endmodule

FILE: rtl/bpsd_checker.sv
// port-level checks of the box point signed distance block, bound to the top level
`include "box_point_signed_distance_top_macros.svh"

module bpsd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [bpsd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                                rsp_tuser
);
   import bpsd_pkg::*;

   // a stalled result stays offered
   `BPSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // and keeps its value
   `BPSD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))

   // reset empties the output and the skid
   `BPSD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready)

   // input back-pressure only follows an output stall
   `BPSD_ASSERT_IMP(a_ready_stall, clock, reset, !req_tready, $past(rsp_tvalid && !rsp_tready))

endmodule

bind box_point_signed_distance_top bpsd_checker u_bpsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
